// ===== sv/a2oti_pkg.sv =====
package a2oti_pkg;

  localparam int TableIndexBits = 8;
  localparam int TblSize        = (1 << TableIndexBits) + 1;
  localparam int IdxW           = TableIndexBits + 1;
  localparam int TblW           = 14;
  localparam int FracW          = 16;
  localparam int CoordW         = 32;
  localparam int AngleW         = 17;
  localparam int BitsPerStage   = 2;
  localparam int DivStages      = CoordW / BitsPerStage;
  localparam int ProdW          = TblW + FracW;
  localparam int SeriesBits     = 40;

  localparam logic [TblW-1:0]   Eighth  = 14'h2000;
  localparam logic [AngleW-1:0] Quarter = 17'h04000;
  localparam logic [AngleW-1:0] Half    = 17'h08000;

  typedef enum logic [2:0] {
    OCT0 = 3'd0, OCT1 = 3'd1, OCT2 = 3'd2, OCT3 = 3'd3,
    OCT4 = 3'd4, OCT5 = 3'd5, OCT6 = 3'd6, OCT7 = 3'd7
  } oct_t;

  typedef struct packed {
    oct_t oct;
    logic eq;
  } side_t;

  typedef logic [TblW-1:0] tbl_t;
  typedef tbl_t tbl_arr_t [TblSize];

  // shift and subtract quotient, used only while building the rom
  function automatic longint unsigned div_u64(longint unsigned nv, longint unsigned dv);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], nv[b]};
      if (r >= dv) begin
        r    = r - dv;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned series_atan(longint unsigned i, longint unsigned n);
    longint unsigned den;
    longint unsigned term;
    longint unsigned sum;
    den  = n * n + i * i;
    term = div_u64((i * n) << SeriesBits, den);
    sum  = term;
    for (longint unsigned k = 1; k < 400 && term != 0; k++) begin
      term = div_u64(term * (2 * k), 2 * k + 1);
      term = div_u64(term * (i * i), den);
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic tbl_arr_t build_table();
    tbl_arr_t        t;
    longint unsigned n;
    longint unsigned pi_f;
    longint unsigned a;
    n    = longint'(1) << TableIndexBits;
    pi_f = 4 * series_atan(n, n);
    for (int i = 0; i < TblSize; i++) begin
      a    = series_atan(longint'(i), n);
      t[i] = TblW'(div_u64((a << 16) + pi_f, 2 * pi_f));
    end
    return t;
  endfunction

  localparam tbl_arr_t AtanTable = build_table();

endpackage

// ===== sv/a2oti_ifs.sv =====
interface a2oti_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [a2oti_pkg::CoordW-1:0] x_coord;
  logic signed [a2oti_pkg::CoordW-1:0] y_coord;
  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

interface a2oti_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [a2oti_pkg::AngleW-1:0] angle;
  modport source (output valid, angle, input ready);
  modport sink (input valid, angle, output ready);
endinterface

// ===== sv/atan2_octant_table_interp_top.sv =====
// path from accepted input word to output word: front, divider, interp, output register
// throughput: one word per cycle unless dout stalls; the 16-stage radix-4 divider sets the depth
// a stall on dout holds every stage in place; din.ready follows dout
// rst (synchronous, active high) clears all valid bits; rom is constant
module atan2_octant_table_interp_top (
  input logic      clk,
  input logic      rst,
  a2oti_in_if.sink   din,
  a2oti_out_if.source dout
);
  import a2oti_pkg::*;

  logic              en;
  logic              fv, dv, iv;
  logic [CoordW-1:0] num, den, ratio;
  side_t             fs, ds, is;
  logic [TblW-1:0]   a;
  logic [AngleW-1:0] as, res;

  assign en        = !dout.valid || dout.ready;
  assign din.ready = en;

  a2oti_front u_front (
    .clk, .rst, .en, .in_valid(din.valid), .x_in(din.x_coord), .y_in(din.y_coord),
    .valid(fv), .num, .den, .side(fs)
  );

  a2oti_div u_div (
    .clk, .rst, .en, .in_valid(fv), .num, .den, .side_in(fs),
    .valid(dv), .ratio, .side(ds)
  );

  a2oti_interp u_interp (
    .clk, .rst, .en, .in_valid(dv), .ratio, .side_in(ds),
    .valid(iv), .a, .side(is)
  );

  assign as = is.eq ? AngleW'(Eighth) : AngleW'(a);

  always_comb begin
    unique case (is.oct)
      OCT1:    res = Quarter - as;
      OCT2:    res = Half - as;
      OCT3:    res = as + Quarter;
      OCT4:    res = -as;
      OCT5:    res = as - Quarter;
      OCT6:    res = as - Half;
      OCT7:    res = -as - Quarter;
      default: res = as;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= iv;
    end
    if (en) begin
      dout.angle <= res;
    end
  end

  a_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.angle >= -17'sd32768 && dout.angle <= 17'sd32768))
    else $error("angle out of range");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !dout.valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(is) && $stable(a) && (iv == $past(iv)))
    else $error("pipeline moved during stall");
endmodule

// ===== sv/a2oti_front.sv =====
module a2oti_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [a2oti_pkg::CoordW-1:0]  x_in,
  input  logic [a2oti_pkg::CoordW-1:0]  y_in,
  output logic                          valid,
  output logic [a2oti_pkg::CoordW-1:0]  num,
  output logic [a2oti_pkg::CoordW-1:0]  den,
  output a2oti_pkg::side_t              side
);
  import a2oti_pkg::*;

  logic              v1;
  logic [CoordW-1:0] ax, ay, ax_next, ay_next;
  logic              sx, sy;
  logic              gt;
  side_t             side_next;

  function automatic logic [CoordW-1:0] mag(logic [CoordW-1:0] v);
    logic [CoordW-1:0] c;
    c = (v == {1'b1, {(CoordW-1){1'b0}}}) ? {1'b1, {(CoordW-2){1'b0}}, 1'b1} : v;
    return c[CoordW-1] ? (~c + 1'b1) : c;
  endfunction

  assign ax_next = mag(x_in);
  assign ay_next = mag(y_in);
  assign gt      = ay < ax;

  always_comb begin
    side_next.eq  = (ax == ay);
    side_next.oct = oct_t'({sx, sy, gt});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      valid <= v1;
    end
    if (en) begin
      ax   <= ax_next;
      ay   <= ay_next;
      sx   <= x_in[CoordW-1];
      sy   <= y_in[CoordW-1];
      num  <= gt ? ay : ax;
      den  <= gt ? ax : ay;
      side <= side_next;
    end
  end
endmodule

// ===== sv/a2oti_div.sv =====
module a2oti_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [a2oti_pkg::CoordW-1:0]  num,
  input  logic [a2oti_pkg::CoordW-1:0]  den,
  input  a2oti_pkg::side_t              side_in,
  output logic                          valid,
  output logic [a2oti_pkg::CoordW-1:0]  ratio,
  output a2oti_pkg::side_t              side
);
  import a2oti_pkg::*;

  logic              v_s   [DivStages+1];
  logic [CoordW:0]   rem_s [DivStages+1];
  logic [CoordW-1:0] q_s   [DivStages+1];
  logic [CoordW-1:0] den_s [DivStages+1];
  side_t             sd_s  [DivStages+1];

  assign v_s[0]   = in_valid;
  assign rem_s[0] = {1'b0, num};
  assign q_s[0]   = '0;
  assign den_s[0] = den;
  assign sd_s[0]  = side_in;

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    logic [CoordW:0]   r_next;
    logic [CoordW-1:0] q_next;

    always_comb begin
      r_next = rem_s[g];
      q_next = q_s[g];
      for (int b = 0; b < BitsPerStage; b++) begin
        r_next = {r_next[CoordW-1:0], 1'b0};
        q_next = {q_next[CoordW-2:0], 1'b0};
        if (r_next >= {1'b0, den_s[g]}) begin
          r_next    = r_next - {1'b0, den_s[g]};
          q_next[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[g+1] <= 1'b0;
      end else if (en) begin
        v_s[g+1] <= v_s[g];
      end
      if (en) begin
        rem_s[g+1] <= r_next;
        q_s[g+1]   <= q_next;
        den_s[g+1] <= den_s[g];
        sd_s[g+1]  <= sd_s[g];
      end
    end
  end

  assign valid = v_s[DivStages];
  assign ratio = q_s[DivStages];
  assign side  = sd_s[DivStages];
endmodule

// ===== sv/a2oti_interp.sv =====
module a2oti_interp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [a2oti_pkg::CoordW-1:0]  ratio,
  input  a2oti_pkg::side_t              side_in,
  output logic                          valid,
  output logic [a2oti_pkg::TblW-1:0]    a,
  output a2oti_pkg::side_t              side
);
  import a2oti_pkg::*;

  logic [IdxW-1:0]  idx;
  logic             v1, v2;
  tbl_t             a0, a1, a0_q;
  logic [FracW-1:0] frac;
  logic [ProdW-1:0] prod;
  side_t            sd1, sd2;

  assign idx = {1'b0, ratio[CoordW-1 -: TableIndexBits]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
    if (en) begin
      a0   <= AtanTable[idx];
      a1   <= AtanTable[idx + 1'b1];
      frac <= ratio[CoordW-1-TableIndexBits -: FracW];
      sd1  <= side_in;
      prod <= ProdW'(a1 - a0) * ProdW'(frac);
      a0_q <= a0;
      sd2  <= sd1;
    end
  end

  assign valid = v2;
  assign a     = a0_q + prod[ProdW-1:FracW];
  assign side  = sd2;
endmodule
